### sv/xyzrgb_pkg.sv
// shared constants, types and rounding helper for the xyz to linear rgb converter
// no dependencies; imported by the top level of the block

package xyzrgb_pkg;

   localparam int FRACTION_BITS_DEF = 16;

   // fixed field widths
   localparam int IN_W   = 20;   // pixel components in and out
   localparam int P1_W   = 53;   // matrix product
   localparam int W2_W   = 24;   // matrix result
   localparam int W3_W   = 25;   // after saturation clip
   localparam int MAG_W  = 23;   // magnitude of the clipped component
   localparam int LP_W   = 57;   // luminance weight product
   localparam int TL_W   = 22;   // target luminance in pixel units
   localparam int NUM_W  = 45;   // rescale numerator, also rescale quotient bits
   localparam int LUM_W  = 24;   // positive luminance used as divisor
   localparam int Q1_W   = 46;   // rounded rescale quotient
   localparam int W6_W   = 47;   // rescaled component
   localparam int MX_W   = 46;   // largest component, luminance clip divisor
   localparam int Q2_W   = IN_W; // luminance clip quotient bits

   // csr register indexes
   localparam logic [1:0] REG_CLIP_SAT = 2'd0;
   localparam logic [1:0] REG_RESCALE  = 2'd1;
   localparam logic [1:0] REG_TARGET   = 2'd2;
   localparam logic [1:0] REG_CLIP_LUM = 2'd3;

   localparam logic [IN_W-1:0] TARGET_RESET = 20'd65536;

   // xyz to linear srgb matrix, q.30
   localparam logic signed [32:0] MAT [3][3] = '{
      '{ 33'sd3525800382, -33'sd1672495053, -33'sd542430828 },
      '{-33'sd1054424954,  33'sd2040835630,  33'sd45207095  },
      '{ 33'sd60519091,   -33'sd221903336,   33'sd1149862737}
   };

   // luminance weights, q.30, and their sum
   localparam logic signed [31:0] LUMW [3] = '{
      32'sd556647124, 32'sd1860125530, 32'sd238444976
   };
   localparam logic [31:0] LSUM = 32'd2655217630;

   localparam logic [IN_W-1:0] OUT_MAX = {1'b0, {(IN_W-1){1'b1}}};
   localparam logic [IN_W-1:0] OUT_MIN = {1'b1, {(IN_W-1){1'b0}}};
   localparam logic [IN_W:0]   POS_LIM = {2'b00, {(IN_W-1){1'b1}}};
   localparam logic [IN_W:0]   NEG_LIM = {2'b01, {(IN_W-1){1'b0}}};

   // sidecar through the rescale divider
   typedef struct packed {
      logic [2:0][W3_W-1:0] w;
      logic                 gamut;
      logic                 rescale;
   } rsc_side_type;

   // sidecar through the luminance clip divider
   typedef struct packed {
      logic [2:0][IN_W-1:0] sat_w;
      logic [2:0]           neg;
      logic [2:0]           big;
      logic                 clip;
      logic                 gamut;
      logic                 lumflag;
   } clip_side_type;

   // round to nearest from q.30, ties away from zero
   function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] v);
      logic [63:0] m;
      logic [63:0] r;
      m = v[63] ? 64'(-v) : 64'(v);
      r = (m + (64'd1 << 29)) >> 30;
      rnd_q30 = v[63] ? -$signed(r) : $signed(r);
   endfunction

endpackage

### sv/xyzrgb_div3.sv
// pipelined restoring divider, one quotient bit per stage, three lanes on a shared divisor
// standalone; the payload sidecar travels alongside unchanged

module xyzrgb_div3 #(
   parameter int D_W = 24,
   parameter int Q_W = 45,
   parameter int P_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [D_W-1:0]       in_den,
   input  logic [2:0][D_W-1:0]  in_rem,
   input  logic [2:0][Q_W-1:0]  in_lq,
   input  logic [P_W-1:0]       in_side,
   output logic                 out_valid,
   output logic [D_W-1:0]       out_den,
   output logic [2:0][D_W-1:0]  out_rem,
   output logic [2:0][Q_W-1:0]  out_lq,
   output logic [P_W-1:0]       out_side
);

   logic                vld_ff  [Q_W];
   logic [D_W-1:0]      den_ff  [Q_W];
   logic [2:0][D_W-1:0] rem_ff  [Q_W];
   logic [2:0][Q_W-1:0] lq_ff   [Q_W];
   logic [P_W-1:0]      side_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic                src_v;
      logic [D_W-1:0]      src_den;
      logic [2:0][D_W-1:0] src_rem;
      logic [2:0][Q_W-1:0] src_lq;
      logic [P_W-1:0]      src_side;
      logic [2:0][D_W-1:0] rem_in;
      logic [2:0][Q_W-1:0] lq_in;

      if (k == 0) begin : g_first
         assign src_v    = in_valid;
         assign src_den  = in_den;
         assign src_rem  = in_rem;
         assign src_lq   = in_lq;
         assign src_side = in_side;
      end else begin : g_next
         assign src_v    = vld_ff[k-1];
         assign src_den  = den_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_lq   = lq_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      // shift in the next numerator bit, subtract when it fits
      always_comb begin
         logic [D_W:0] t;
         logic [D_W:0] diff;
         logic         ge;
         for (int l = 0; l < 3; l++) begin
            t    = {src_rem[l], src_lq[l][Q_W-1]};
            diff = t - {1'b0, src_den};
            ge   = t >= {1'b0, src_den};
            rem_in[l] = ge ? diff[D_W-1:0] : t[D_W-1:0];
            lq_in[l]  = {src_lq[l][Q_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k]  <= src_den;
            rem_ff[k]  <= rem_in;
            lq_ff[k]   <= lq_in;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_den   = den_ff[Q_W-1];
   assign out_rem   = rem_ff[Q_W-1];
   assign out_lq    = lq_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_rem[0] < out_den) && (out_rem[1] < out_den) && (out_rem[2] < out_den))
      else $error("divider remainder not below divisor");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_den != '0)
      else $error("divider saw a zero divisor");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(out_valid))
      else $error("divider moved while held");

endmodule

### sv/xyz_to_linear_rgb_gamut_clip_core.sv
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tdata: x_in, y_in, z_in
// rsp      out  rsp_tvalid/tready     tdata: red, green, blue; tuser: two flags
// csr      in   apb, pready high      four control registers
//
// one beat per cycle unless the output stalls; 5 matrix and luminance stages,
// 45 stages of the rescale divider, 3 clip stages, 20 stages of the clip divider
// and the output register. the divider stage counts set the latency.
// reset is synchronous and clears valid bits and csr registers only.
// the whole pipeline holds while a result waits at the output.
// top level of the xyz to linear rgb converter; uses xyzrgb_pkg and xyzrgb_div3

module xyz_to_linear_rgb_gamut_clip_core import xyzrgb_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // x_in, y_in, z_in, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // red, green, blue, zero fill
   output logic [1:0]  rsp_tuser,   // gamut_flag, lum_flag
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [MX_W-1:0]        ONE   = MX_W'(1) << FRACTION_BITS;
   localparam logic signed [W6_W-1:0] ONE_S = $signed({1'b0, ONE});
   localparam int                     NW    = MX_W + FRACTION_BITS;

   // csr registers
   logic            clip_sat_ff, relum_ff, clip_lum_ff;
   logic [IN_W-1:0] target_ff;
   logic [TL_W-1:0] tl_ff;
   logic            wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_sat_ff <= 1'b1;
         relum_ff    <= 1'b0;
         target_ff   <= TARGET_RESET;
         clip_lum_ff <= 1'b1;
      end else if (wr) begin
         case (csr_paddr[3:2])
            REG_CLIP_SAT: clip_sat_ff <= csr_pwdata[0];
            REG_RESCALE:  relum_ff    <= csr_pwdata[0];
            REG_TARGET:   target_ff   <= csr_pwdata[IN_W-1:0];
            REG_CLIP_LUM: clip_lum_ff <= csr_pwdata[0];
            default:      clip_sat_ff <= clip_sat_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CLIP_SAT: csr_prdata = 32'(clip_sat_ff);
         REG_RESCALE:  csr_prdata = 32'(relum_ff);
         REG_TARGET:   csr_prdata = 32'(target_ff);
         REG_CLIP_LUM: csr_prdata = 32'(clip_lum_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // target luminance of white at the chosen level
   always_ff @(posedge clock) begin
      tl_ff <= TL_W'(((64'(LSUM) * 64'(target_ff)) + (64'd1 << 29)) >> 30);
   end

   // pipeline advance
   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic d1_valid, d2_valid;

   // stage 1: matrix products
   logic signed [IN_W-1:0] vin [3];
   logic signed [P1_W-1:0] p1_in [3][3];
   logic signed [P1_W-1:0] p1_ff [3][3];

   assign vin[0] = $signed(req_tdata[IN_W-1:0]);
   assign vin[1] = $signed(req_tdata[2*IN_W-1:IN_W]);
   assign vin[2] = $signed(req_tdata[3*IN_W-1:2*IN_W]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p1_in[i][j] = MAT[i][j] * vin[j];
         end
      end
   end

   // stage 2: row sums, rounded
   logic signed [W2_W-1:0] w2_in [3];
   logic signed [W2_W-1:0] w2_ff [3];

   always_comb begin
      logic signed [63:0] acc;
      logic signed [63:0] r;
      for (int i = 0; i < 3; i++) begin
         acc = 64'(p1_ff[i][0]) + 64'(p1_ff[i][1]) + 64'(p1_ff[i][2]);
         r   = rnd_q30(acc);
         w2_in[i] = r[W2_W-1:0];
      end
   end

   // stage 3: gamut flag and, with saturation clip on, lift by the most negative component
   logic                   gam3_in, gam3_ff;
   logic signed [W3_W-1:0] w3_in [3];
   logic signed [W3_W-1:0] w3_ff [3];

   always_comb begin
      logic signed [W2_W-1:0] mn;
      gam3_in = w2_ff[0][W2_W-1] | w2_ff[1][W2_W-1] | w2_ff[2][W2_W-1];
      mn = '0;
      for (int i = 0; i < 3; i++) begin
         if (w2_ff[i] < mn) mn = w2_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         w3_in[i] = (clip_sat_ff && gam3_in) ? W3_W'(w2_ff[i]) - W3_W'(mn)
                                             : W3_W'(w2_ff[i]);
      end
   end

   // stage 4: luminance products and rescale numerators
   logic signed [LP_W-1:0]  lp_in [3];
   logic signed [LP_W-1:0]  lp_ff [3];
   logic [NUM_W-1:0]        np_in [3];
   logic [NUM_W-1:0]        np_ff [3];
   logic signed [W3_W-1:0]  w4_ff [3];
   logic                    gam4_ff;

   always_comb begin
      logic [W3_W-1:0] m;
      for (int i = 0; i < 3; i++) begin
         lp_in[i] = LUMW[i] * w3_ff[i];
         m = w3_ff[i][W3_W-1] ? W3_W'(-w3_ff[i]) : W3_W'(w3_ff[i]);
         np_in[i] = NUM_W'(m[MAG_W-1:0]) * NUM_W'(tl_ff);
      end
   end

   // stage 5: luminance and rescale decision
   logic                    resc5_in, resc5_ff;
   logic [LUM_W-1:0]        den5_in, den5_ff;
   logic [2:0][NUM_W-1:0]   num5_ff;
   logic signed [W3_W-1:0]  w5_ff [3];
   logic                    gam5_ff;

   always_comb begin
      logic signed [63:0] acc;
      logic signed [63:0] lum;
      acc = 64'(lp_ff[0]) + 64'(lp_ff[1]) + 64'(lp_ff[2]);
      lum = rnd_q30(acc);
      resc5_in = relum_ff && (lum > 64'sd0);
      den5_in  = resc5_in ? lum[LUM_W-1:0] : LUM_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= p1_in;
         w2_ff   <= w2_in;
         w3_ff   <= w3_in;
         gam3_ff <= gam3_in;
         lp_ff   <= lp_in;
         np_ff   <= np_in;
         w4_ff   <= w3_ff;
         gam4_ff <= gam3_ff;
         resc5_ff <= resc5_in;
         den5_ff <= den5_in;
         for (int i = 0; i < 3; i++) begin
            num5_ff[i] <= np_ff[i];
         end
         w5_ff   <= w4_ff;
         gam5_ff <= gam4_ff;
      end
   end

   // rescale divider: round(|w| * tl / lum)
   rsc_side_type          side1_in, side1_out;
   logic [LUM_W-1:0]      d1_den;
   logic [2:0][LUM_W-1:0] d1_rem;
   logic [2:0][NUM_W-1:0] d1_lq;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         side1_in.w[i] = w5_ff[i];
      end
      side1_in.gamut   = gam5_ff;
      side1_in.rescale = resc5_ff;
   end

   xyzrgb_div3 #(
      .D_W (LUM_W),
      .Q_W (NUM_W),
      .P_W ($bits(rsc_side_type))
   ) u_div_rescale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_den    (den5_ff),
      .in_rem    ('0),
      .in_lq     (num5_ff),
      .in_side   (side1_in),
      .out_valid (d1_valid),
      .out_den   (d1_den),
      .out_rem   (d1_rem),
      .out_lq    (d1_lq),
      .out_side  (side1_out)
   );

   // stage 6: round quotient and restore sign, or pass the component through without rescale
   logic signed [W6_W-1:0] w6_in [3];
   logic signed [W6_W-1:0] w6_ff [3];
   logic                   gam6_ff;

   always_comb begin
      logic                   up;
      logic [Q1_W-1:0]        q;
      logic signed [W6_W-1:0] qs;
      logic signed [W3_W-1:0] sw;
      for (int i = 0; i < 3; i++) begin
         up = {d1_rem[i], 1'b0} >= {1'b0, d1_den};
         q  = Q1_W'(d1_lq[i]) + Q1_W'(up);
         qs = $signed({1'b0, q});
         sw = $signed(side1_out.w[i]);
         w6_in[i] = side1_out.rescale ? (sw[W3_W-1] ? -qs : qs) : W6_W'(sw);
      end
   end

   // stage 7: luminance flag, largest component, magnitudes and saturated values
   logic                  lumf7_in, lumf7_ff, clip7_ff, gam7_ff;
   logic [MX_W-1:0]       mx7_in, mx7_ff;
   logic [MX_W-1:0]       a7_in [3];
   logic [MX_W-1:0]       a7_ff [3];
   logic [2:0]            neg7_in, neg7_ff;
   logic [IN_W-1:0]       sat7_in [3];
   logic [IN_W-1:0]       sat7_ff [3];

   always_comb begin
      logic signed [W6_W-1:0] mx;
      logic signed [W6_W-1:0] am;
      lumf7_in = 1'b0;
      mx = ONE_S;
      for (int i = 0; i < 3; i++) begin
         if (w6_ff[i] > ONE_S) lumf7_in = 1'b1;
         if (w6_ff[i] > mx) mx = w6_ff[i];
         neg7_in[i] = w6_ff[i][W6_W-1];
         am = neg7_in[i] ? -w6_ff[i] : w6_ff[i];
         a7_in[i] = am[MX_W-1:0];
         if (w6_ff[i] > W6_W'($signed(OUT_MAX))) begin
            sat7_in[i] = OUT_MAX;
         end else if (w6_ff[i] < W6_W'($signed(OUT_MIN))) begin
            sat7_in[i] = OUT_MIN;
         end else begin
            sat7_in[i] = w6_ff[i][IN_W-1:0];
         end
      end
      mx7_in = mx[MX_W-1:0];
   end

   // stage 8: overflow test and clip divider set-up
   logic [2:0]            big8_in;
   logic [2:0][MX_W-1:0]  rem8_in, rem8_ff;
   logic [2:0][Q2_W-1:0]  lq8_in, lq8_ff;
   logic [MX_W-1:0]       mx8_ff;
   clip_side_type         side2_in, side2_ff, side2_out;

   always_comb begin
      logic [NW-1:0]           a_sh;
      logic [MX_W+Q2_W-1:0]    mx_sh;
      logic [NW+MX_W-1:0]      ext;
      mx_sh = {mx7_ff, {Q2_W{1'b0}}};
      for (int i = 0; i < 3; i++) begin
         a_sh = {a7_ff[i], {FRACTION_BITS{1'b0}}};
         ext  = (NW+MX_W)'(a_sh);
         // quotient would not fit the output range
         big8_in[i] = a_sh >= mx_sh;
         if (clip7_ff && !big8_in[i]) begin
            rem8_in[i] = ext[MX_W+Q2_W-1:Q2_W];
            lq8_in[i]  = a_sh[Q2_W-1:0];
         end else begin
            rem8_in[i] = '0;
            lq8_in[i]  = '0;
         end
         side2_in.sat_w[i] = sat7_ff[i];
      end
      side2_in.neg     = neg7_ff;
      side2_in.big     = big8_in;
      side2_in.clip    = clip7_ff;
      side2_in.gamut   = gam7_ff;
      side2_in.lumflag = lumf7_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= d1_valid;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w6_ff    <= w6_in;
         gam6_ff  <= side1_out.gamut;
         lumf7_ff <= lumf7_in;
         clip7_ff <= lumf7_in && clip_lum_ff;
         gam7_ff  <= gam6_ff;
         mx7_ff   <= mx7_in;
         a7_ff    <= a7_in;
         neg7_ff  <= neg7_in;
         sat7_ff  <= sat7_in;
         rem8_ff  <= rem8_in;
         lq8_ff   <= lq8_in;
         mx8_ff   <= mx7_ff;
         side2_ff <= side2_in;
      end
   end

   // luminance clip divider: round(|w| * one / max)
   logic [MX_W-1:0]       d2_den;
   logic [2:0][MX_W-1:0]  d2_rem;
   logic [2:0][Q2_W-1:0]  d2_lq;

   xyzrgb_div3 #(
      .D_W (MX_W),
      .Q_W (Q2_W),
      .P_W ($bits(clip_side_type))
   ) u_div_clip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v8_ff),
      .in_den    (mx8_ff),
      .in_rem    (rem8_ff),
      .in_lq     (lq8_ff),
      .in_side   (side2_ff),
      .out_valid (d2_valid),
      .out_den   (d2_den),
      .out_rem   (d2_rem),
      .out_lq    (d2_lq),
      .out_side  (side2_out)
   );

   // output stage: round, sign and saturate
   logic [IN_W-1:0] out_in [3];
   logic [IN_W-1:0] out_ff [3];
   logic            gam_ff, lumf_ff;

   always_comb begin
      logic          up;
      logic [IN_W:0] q;
      logic [IN_W:0] nq;
      for (int i = 0; i < 3; i++) begin
         up = {d2_rem[i], 1'b0} >= {1'b0, d2_den};
         q  = (IN_W+1)'(d2_lq[i]) + (IN_W+1)'(up);
         nq = -q;
         if (!side2_out.clip) begin
            out_in[i] = side2_out.sat_w[i];
         end else if (side2_out.neg[i]) begin
            out_in[i] = (side2_out.big[i] || q > NEG_LIM) ? OUT_MIN : nq[IN_W-1:0];
         end else begin
            out_in[i] = (side2_out.big[i] || q > POS_LIM) ? OUT_MAX : q[IN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff  <= out_in;
         gam_ff  <= side2_out.gamut;
         lumf_ff <= side2_out.lumflag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff[2], out_ff[1], out_ff[0]};
   assign rsp_tuser  = {lumf_ff, gam_ff};

   // an in-gamut pixel never comes out negative
   a_in_gamut_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !gam_ff |->
         !out_ff[0][IN_W-1] && !out_ff[1][IN_W-1] && !out_ff[2][IN_W-1])
      else $error("negative component on an in-gamut beat");

   // without the luminance flag no component is above one
   a_no_lum_flag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !lumf_ff |->
         ($signed(out_ff[0]) <= ONE_S) && ($signed(out_ff[1]) <= ONE_S) &&
         ($signed(out_ff[2]) <= ONE_S))
      else $error("component above one without luminance flag");

   // a waiting beat stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

endmodule
